FILE: design/sha1mh_pkg.sv
// Shared types, constants and helper functions for the SHA-1 message hasher.
// No dependencies; every other file of the block imports this package.
package sha1mh_pkg;

    typedef logic [31:0] t_word;

    // Working variables a..e, also used for the chaining state.
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_vars;

    // Control from the sequencer to the message schedule.
    typedef struct packed {
        logic shift;   // move the window by one word
        logic expand;  // shift in the expanded word instead of the pushed one
    } t_sched_ctl;

    localparam int DIGEST_WORDS = 5;
    localparam int ROUNDS       = 80;

    localparam t_word INIT_CHAIN [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam t_word K_ROUND0 = 32'h5A827999;
    localparam t_word K_ROUND1 = 32'h6ED9EBA1;
    localparam t_word K_ROUND2 = 32'h8F1BBCDC;
    localparam t_word K_ROUND3 = 32'hCA62C1D6;

    localparam t_word PAD_WORD = 32'h80000000;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic t_word rotl1(input t_word v);
        return {v[30:0], v[31]};
    endfunction

    function automatic t_word rotl5(input t_word v);
        return {v[26:0], v[31:27]};
    endfunction

    function automatic t_word rotl30(input t_word v);
        return {v[1:0], v[31:2]};
    endfunction

endpackage

FILE: design/sha1mh_sched.sv
// Message schedule of the SHA-1 hasher: a 16-word sliding window.
// Depends on sha1mh_pkg. Incoming words and expanded words enter at the top.
module sha1mh_sched (
    input  logic                    i_clk,
    input  sha1mh_pkg::t_sched_ctl  i_ctl,
    input  sha1mh_pkg::t_word       i_word,
    output sha1mh_pkg::t_word       o_w
);
    import sha1mh_pkg::*;

    // r_win[j] holds schedule word w[r + j] during round r.
    t_word r_win [16];
    t_word w_expand;

    assign w_expand = rotl1(r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0]);
    assign o_w      = r_win[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            for (int j = 0; j < 15; j++) begin
                r_win[j] <= r_win[j + 1];
            end
            r_win[15] <= i_ctl.expand ? w_expand : i_word;
        end
    end

endmodule

FILE: design/sha1mh_round.sv
// One SHA-1 round: the shared compression datapath, used once per cycle.
// Depends on sha1mh_pkg for the variable struct, round constants and rotates.
module sha1mh_round (
    input  sha1mh_pkg::t_vars  i_vars,
    input  sha1mh_pkg::t_word  i_w,
    input  logic [6:0]         i_round,
    output sha1mh_pkg::t_vars  o_vars
);
    import sha1mh_pkg::*;

    t_word f;
    t_word k;

    always_comb begin
        if (i_round < 7'd20) begin
            f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            k = K_ROUND0;
        end else if (i_round < 7'd40) begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_ROUND1;
        end else if (i_round < 7'd60) begin
            f = (i_vars.b & i_vars.c) | (i_vars.b & i_vars.d) | (i_vars.c & i_vars.d);
            k = K_ROUND2;
        end else begin
            f = i_vars.b ^ i_vars.c ^ i_vars.d;
            k = K_ROUND3;
        end
    end

    assign o_vars.a = rotl5(i_vars.a) + f + i_vars.e + k + i_w;
    assign o_vars.b = i_vars.a;
    assign o_vars.c = rotl30(i_vars.b);
    assign o_vars.d = i_vars.c;
    assign o_vars.e = i_vars.d;

endmodule

FILE: design/sha1_message_hasher.sv
// SHA-1 message hasher. Each accepted request is one big-endian message word; the block
// takes one word per cycle until 16 are held, then runs the 80 rounds through a single
// shared round unit, one round per cycle, and an add step then sums the result into the
// chaining state. On the word marked last (tlast) the block pads the message itself, one
// padding word per cycle, which adds one or two further compressions, and then offers
// the five digest words, most significant first. Input tready is low while a block is
// compressed, while padding runs and while the digest is being taken. After the fifth
// digest word the chaining state is back at the SHA-1 initial values and the next
// message may start.
// Depends on sha1mh_pkg, sha1mh_sched and sha1mh_round.
module sha1_message_hasher (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  sha1mh_pkg::t_word        s_axis_tdata,   // [31:0] data_word
    input  logic [2:0]               s_axis_tuser,   // [2:0] byte_count
    input  logic                     s_axis_tlast,   // final_item
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output sha1mh_pkg::t_word        m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]               m_axis_tuser,   // [2:0] word_index
    output logic                     m_axis_tlast    // last_word
);
    import sha1mh_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
    localparam logic [2:0] LAST_INDEX = 3'(DIGEST_WORDS - 1);

    logic [2:0]  r_state,   n_state;
    logic [3:0]  r_fill,    n_fill;
    logic [60:0] r_bytes,   n_bytes;
    t_vars       r_chain,   n_chain;
    t_vars       r_work,    n_work;
    logic [6:0]  r_round,   n_round;
    logic        r_pend80,  n_pend80;
    logic        r_len_ok,  n_len_ok;
    logic        r_in_pad,  n_in_pad;
    logic        r_last_blk, n_last_blk;
    logic [2:0]  r_oidx,    n_oidx;

    t_sched_ctl  sched_ctl;
    t_word       push_word;
    t_word       sched_w;
    t_vars       round_vars;
    logic        push;
    logic        in_acc;
    logic        out_acc;
    logic [2:0]  nbytes;
    logic [63:0] bit_len;
    t_word       first_word;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = r_chain.a;
    assign m_axis_tuser  = r_oidx;
    assign m_axis_tlast  = (r_oidx == LAST_INDEX);

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign nbytes  = (s_axis_tuser > 3'd4) ? 3'd4 : s_axis_tuser;
    assign bit_len = {r_bytes, 3'b000};

    // Final word: keep the valid leading bytes, then the 0x80 byte if fewer than four.
    always_comb begin
        case (nbytes)
            3'd0:    first_word = {PAD_BYTE, 24'h0};
            3'd1:    first_word = {s_axis_tdata[31:24], PAD_BYTE, 16'h0};
            3'd2:    first_word = {s_axis_tdata[31:16], PAD_BYTE, 8'h0};
            3'd3:    first_word = {s_axis_tdata[31:8], PAD_BYTE};
            default: first_word = s_axis_tdata;
        endcase
    end

    sha1mh_sched u_sched (
        .i_clk  (i_clk),
        .i_ctl  (sched_ctl),
        .i_word (push_word),
        .o_w    (sched_w)
    );

    sha1mh_round u_round (
        .i_vars  (r_work),
        .i_w     (sched_w),
        .i_round (r_round),
        .o_vars  (round_vars)
    );

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_bytes    = r_bytes;
        n_chain    = r_chain;
        n_work     = r_work;
        n_round    = r_round;
        n_pend80   = r_pend80;
        n_len_ok   = r_len_ok;
        n_in_pad   = r_in_pad;
        n_last_blk = r_last_blk;
        n_oidx     = r_oidx;
        push       = 1'b0;
        push_word  = s_axis_tdata;
        sched_ctl  = '0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    push = 1'b1;
                    if (!s_axis_tlast) begin
                        n_bytes = r_bytes + 61'd4;
                    end else begin
                        n_bytes   = r_bytes + 61'(nbytes);
                        push_word = first_word;
                        n_pend80  = (nbytes == 3'd4);
                        n_len_ok  = (nbytes != 3'd4) && (r_fill <= 4'd13);
                        n_in_pad  = 1'b1;
                        n_state   = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                push = 1'b1;
                if (r_pend80) begin
                    push_word = PAD_WORD;
                    n_pend80  = 1'b0;
                    n_len_ok  = (r_fill <= 4'd13);
                end else if (r_len_ok && r_fill == 4'd14) begin
                    push_word = bit_len[63:32];
                end else if (r_len_ok && r_fill == 4'd15) begin
                    push_word  = bit_len[31:0];
                    n_last_blk = 1'b1;
                end else begin
                    push_word = '0;
                end
            end
            ST_ROUND: begin
                sched_ctl.shift  = 1'b1;
                sched_ctl.expand = 1'b1;
                n_work  = round_vars;
                n_round = r_round + 7'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_chain.a = r_chain.a + r_work.a;
                n_chain.b = r_chain.b + r_work.b;
                n_chain.c = r_chain.c + r_work.c;
                n_chain.d = r_chain.d + r_work.d;
                n_chain.e = r_chain.e + r_work.e;
                n_round   = '0;
                if (r_last_blk) begin
                    n_state = ST_OUT;
                end else if (r_in_pad) begin
                    // A fresh block during padding always has room for the length.
                    n_len_ok = 1'b1;
                    n_state  = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_acc) begin
                    // Shift the digest out; the initial values follow it in.
                    n_chain.a = r_chain.b;
                    n_chain.b = r_chain.c;
                    n_chain.c = r_chain.d;
                    n_chain.d = r_chain.e;
                    n_chain.e = INIT_CHAIN[r_oidx];
                    n_oidx    = r_oidx + 3'd1;
                    if (r_oidx == LAST_INDEX) begin
                        n_oidx     = '0;
                        n_bytes    = '0;
                        n_in_pad   = 1'b0;
                        n_last_blk = 1'b0;
                        n_len_ok   = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (push) begin
            sched_ctl.shift = 1'b1;
            n_fill = r_fill + 4'd1;
            if (r_fill == 4'd15) begin
                n_work  = r_chain;
                n_round = '0;
                n_state = ST_ROUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fill     <= '0;
            r_bytes    <= '0;
            r_chain    <= {INIT_CHAIN[0], INIT_CHAIN[1], INIT_CHAIN[2],
                           INIT_CHAIN[3], INIT_CHAIN[4]};
            r_work     <= '0;
            r_round    <= '0;
            r_pend80   <= 1'b0;
            r_len_ok   <= 1'b0;
            r_in_pad   <= 1'b0;
            r_last_blk <= 1'b0;
            r_oidx     <= '0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_bytes    <= n_bytes;
            r_chain    <= n_chain;
            r_work     <= n_work;
            r_round    <= n_round;
            r_pend80   <= n_pend80;
            r_len_ok   <= n_len_ok;
            r_in_pad   <= n_in_pad;
            r_last_blk <= n_last_blk;
            r_oidx     <= n_oidx;
        end
    end

    // The input side never takes a request while a digest is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while digest pending");

    // After the fifth digest word the block starts a fresh, empty message.
    a_msg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && m_axis_tlast) |=> (r_fill == 4'd0 && r_bytes == 61'd0 && !r_in_pad))
        else $error("message state not cleared after digest");

    // A compression always begins with an empty block and a zero round count.
    a_round_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_ROUND && n_state == ST_ROUND) |=> (r_round == 7'd0 && r_fill == 4'd0))
        else $error("compression started mid-block");

    // After the final block is added, the digest output starts with word zero.
    a_last_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD && r_last_blk) |=> (r_state == ST_OUT && r_oidx == 3'd0))
        else $error("digest output not started after final block");

endmodule
